FILE: hdl/mie_pkg.sv
// Shared types, long-operation codes, divider constants and exception codes for the integer execute core.
package mie_pkg;

	localparam logic [2:0] EXC_NONE = 3'd0;
	localparam logic [2:0] EXC_OVF  = 3'd1;
	localparam logic [2:0] EXC_SYS  = 3'd2;
	localparam logic [2:0] EXC_BRK  = 3'd3;
	localparam logic [2:0] EXC_RI   = 3'd4;
	localparam logic [2:0] EXC_UNH  = 3'd5;

	localparam int DIV_STEPS = 32;
	localparam int CNT_W = $clog2(DIV_STEPS + 1);

	// long-running hi/lo operation requested by decode
	localparam logic [1:0] LONG_NONE = 2'd0;
	localparam logic [1:0] LONG_MUL  = 2'd1;
	localparam logic [1:0] LONG_DIV  = 2'd2;

	typedef struct packed {
		logic load;       // capture instruction, operands and pc
		logic mul_start;
		logic div_start;
		logic div_step;
		logic finish;     // commit multiply/divide result to hi/lo
	} mie_cmd_t;

	typedef struct packed {
		logic [1:0] long_op;
		logic       step_last;
	} mie_sts_t;

endpackage

FILE: hdl/mie_ctrl.sv
// Controller: sequences one item through decode, multiply or divide, and output.
module mie_ctrl import mie_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	input  mie_sts_t sts,
	output mie_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DEC  = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	logic [2:0] state_q, state_d;
	logic       out_done;

	assign out_done  = (state_q == ST_OUT) && !out_stall;
	// take a new item also while the previous result is being taken
	assign in_stall  = !((state_q == ST_IDLE) || out_done);
	assign out_valid = (state_q == ST_OUT);

	always_comb begin
		cmd = '0;
		state_d = state_q;
		cmd.load = in_valid && !in_stall;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_DEC;
			end
			ST_DEC: begin
				if (sts.long_op == LONG_MUL) begin
					cmd.mul_start = 1'b1;
					state_d = ST_MUL;
				end else if (sts.long_op == LONG_DIV) begin
					cmd.div_start = 1'b1;
					state_d = ST_DIV;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_MUL: state_d = ST_FIN;
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.step_last) state_d = ST_FIN;
			end
			ST_FIN: begin
				cmd.finish = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!out_stall) state_d = in_valid ? ST_DEC : ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

endmodule

FILE: hdl/mie_dp.sv
// Datapath: decode, ALU, branch resolve, multiplier, restoring divider and hi/lo.
module mie_dp import mie_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  mie_cmd_t    cmd,
	output mie_sts_t    sts,
	input  logic [31:0] instruction,
	input  logic [31:0] rs_value,
	input  logic [31:0] rt_value,
	input  logic [31:0] pc,
	output logic        reg_write,
	output logic [4:0]  dest_reg,
	output logic [31:0] write_data,
	output logic        redirect,
	output logic [31:0] target_pc,
	output logic [2:0]  exception
);

	logic [31:0] ins_q, a_q, b_q, pc_q;
	logic [31:0] hi_q, lo_q;

	logic [5:0]  op, fn;
	logic [4:0]  rs, rt, rd, sa;
	logic [31:0] uimm, simm, pc4, pc8, btgt;
	logic        we;
	logic [4:0]  wr;
	logic [31:0] wd;
	logic        redir;
	logic [31:0] tgt;
	logic [2:0]  exc;
	logic [1:0]  long_op;
	logic        long_sgn;
	logic        mthi, mtlo;
	logic [31:0] sum, dif, isum;
	logic        a_neg;

	assign op = ins_q[31:26];
	assign rs = ins_q[25:21];
	assign rt = ins_q[20:16];
	assign rd = ins_q[15:11];
	assign sa = ins_q[10:6];
	assign fn = ins_q[5:0];
	assign uimm = {16'd0, ins_q[15:0]};
	assign simm = {{16{ins_q[15]}}, ins_q[15:0]};
	assign pc4 = pc_q + 32'd4;
	assign pc8 = pc_q + 32'd8;
	assign btgt = pc4 + {simm[29:0], 2'b00};
	assign sum = a_q + b_q;
	assign dif = a_q - b_q;
	assign isum = a_q + simm;
	assign a_neg = a_q[31];

	always_comb begin
		we = 1'b0; wr = '0; wd = '0; redir = 1'b0; tgt = '0; exc = EXC_NONE;
		long_op = LONG_NONE; long_sgn = 1'b0;
		mthi = 1'b0; mtlo = 1'b0;
		unique case (op)
			6'h00: begin
				wr = rd;
				if (sa == 5'd0 && fn >= 6'h20 && fn <= 6'h2B && fn != 6'h28 && fn != 6'h29) begin
					we = 1'b1;
					case (fn)
						6'h20: begin
							wd = sum;
							if (((a_q ^ sum) & (b_q ^ sum)) >> 31 != 32'd0) begin
								we = 1'b0; exc = EXC_OVF;
							end
						end
						6'h21: wd = sum;
						6'h22: begin
							wd = dif;
							if (((a_q ^ b_q) & (a_q ^ dif)) >> 31 != 32'd0) begin
								we = 1'b0; exc = EXC_OVF;
							end
						end
						6'h23: wd = dif;
						6'h24: wd = a_q & b_q;
						6'h25: wd = a_q | b_q;
						6'h26: wd = a_q ^ b_q;
						6'h27: wd = ~(a_q | b_q);
						6'h2A: wd = {31'd0, $signed(a_q) < $signed(b_q)};
						default: wd = {31'd0, a_q < b_q};
					endcase
				end else if (rs == 5'd0 && fn == 6'h00) begin
					we = 1'b1; wd = b_q << sa;
				end else if (rs == 5'd0 && fn == 6'h02) begin
					we = 1'b1; wd = b_q >> sa;
				end else if (rs == 5'd0 && fn == 6'h03) begin
					we = 1'b1; wd = $unsigned($signed(b_q) >>> sa);
				end else if (sa == 5'd0 && fn == 6'h04) begin
					we = 1'b1; wd = b_q << a_q[4:0];
				end else if (sa == 5'd0 && fn == 6'h06) begin
					we = 1'b1; wd = b_q >> a_q[4:0];
				end else if (sa == 5'd0 && fn == 6'h07) begin
					we = 1'b1; wd = $unsigned($signed(b_q) >>> a_q[4:0]);
				end else if (rd == 5'd0 && sa == 5'd0 && fn >= 6'h18 && fn <= 6'h1B) begin
					long_op = fn[1] ? LONG_DIV : LONG_MUL;
					long_sgn = !fn[0];
				end else if (rs == 5'd0 && rt == 5'd0 && sa == 5'd0 && fn == 6'h10) begin
					we = 1'b1; wd = hi_q;
				end else if (rs == 5'd0 && rt == 5'd0 && sa == 5'd0 && fn == 6'h12) begin
					we = 1'b1; wd = lo_q;
				end else if (rt == 5'd0 && rd == 5'd0 && sa == 5'd0 && fn == 6'h11) begin
					mthi = 1'b1;
				end else if (rt == 5'd0 && rd == 5'd0 && sa == 5'd0 && fn == 6'h13) begin
					mtlo = 1'b1;
				end else if (fn == 6'h0D) begin
					exc = EXC_BRK;
				end else if (fn == 6'h0C) begin
					exc = EXC_SYS;
				end else if (rt == 5'd0 && rd == 5'd0 && sa == 5'd0 && fn == 6'h08) begin
					redir = 1'b1; tgt = a_q;
				end else if (rt == 5'd0 && sa == 5'd0 && fn == 6'h09) begin
					redir = 1'b1; tgt = a_q; we = 1'b1; wd = pc8;
				end else begin
					exc = EXC_RI;
				end
			end
			6'h01: begin
				wr = 5'd31; wd = pc8;
				if (rt == 5'd0 || rt == 5'd16) begin
					redir = a_neg; we = rt[4];
				end else if (rt == 5'd1 || rt == 5'd17) begin
					redir = !a_neg; we = rt[4];
				end else begin
					exc = EXC_RI;
				end
				tgt = btgt;
			end
			6'h02, 6'h03: begin
				redir = 1'b1;
				tgt = {pc4[31:28], ins_q[25:0], 2'b00};
				we = op[0]; wr = 5'd31; wd = pc8;
			end
			6'h04: begin redir = (a_q == b_q); tgt = btgt; end
			6'h05: begin redir = (a_q != b_q); tgt = btgt; end
			6'h06: begin
				if (rt == 5'd0) begin
					redir = a_neg || (a_q == 32'd0); tgt = btgt;
				end else exc = EXC_RI;
			end
			6'h07: begin
				if (rt == 5'd0) begin
					redir = !a_neg && (a_q != 32'd0); tgt = btgt;
				end else exc = EXC_RI;
			end
			6'h08: begin
				wr = rt; wd = isum;
				if (((a_q ^ isum) & (simm ^ isum)) >> 31 != 32'd0) exc = EXC_OVF;
				else we = 1'b1;
			end
			6'h09: begin we = 1'b1; wr = rt; wd = isum; end
			6'h0A: begin we = 1'b1; wr = rt; wd = {31'd0, $signed(a_q) < $signed(simm)}; end
			6'h0B: begin we = 1'b1; wr = rt; wd = {31'd0, a_q < simm}; end
			6'h0C: begin we = 1'b1; wr = rt; wd = a_q & uimm; end
			6'h0D: begin we = 1'b1; wr = rt; wd = a_q | uimm; end
			6'h0E: begin we = 1'b1; wr = rt; wd = a_q ^ uimm; end
			6'h0F: begin
				if (rs == 5'd0) begin
					we = 1'b1; wr = rt; wd = {ins_q[15:0], 16'd0};
				end else exc = EXC_RI;
			end
			6'h10: begin
				exc = EXC_RI;
				if ((rs == 5'd0 || rs == 5'd4) && ins_q[10:3] == 8'd0) exc = EXC_UNH;
				else if (rs == 5'd16 && ins_q[24:6] == 19'd0 &&
					(fn == 6'h18 || fn == 6'h08 || fn == 6'h01 || fn == 6'h02 || fn == 6'h06))
					exc = EXC_UNH;
			end
			6'h20, 6'h21, 6'h22, 6'h23, 6'h24, 6'h25, 6'h26,
			6'h28, 6'h29, 6'h2A, 6'h2B, 6'h2E: exc = EXC_UNH;
			default: exc = EXC_RI;
		endcase
		if (wr == 5'd0) we = 1'b0;
		if (!we) begin wr = '0; wd = '0; end
		if (!redir) tgt = '0;
	end

	// multiplier: 33x33 signed product registered once
	logic signed [32:0] ma, mb;
	logic [63:0]        prod_q;
	assign ma = {long_sgn & a_q[31], a_q};
	assign mb = {long_sgn & b_q[31], b_q};

	// restoring divider on magnitudes, one quotient bit per cycle
	logic [31:0]      dvd_q, dvs_q, rem_q;
	logic             neg_q_q, neg_r_q, dzero_q, isdiv_q;
	logic [CNT_W-1:0] cnt_q;
	logic [32:0]      trial;
	logic [31:0]      rem_sh;
	logic [31:0]      qv, rv;

	assign rem_sh = {rem_q[30:0], dvd_q[31]};
	assign trial = {rem_q[31], rem_sh} - {1'b0, dvs_q};
	assign sts = '{long_op: long_op, step_last: (cnt_q == CNT_W'(DIV_STEPS - 1))};
	assign qv = neg_q_q ? (32'd0 - dvd_q) : dvd_q;
	assign rv = neg_r_q ? (32'd0 - rem_q) : rem_q;

	// start from a harmless encoding so hi/lo hold their reset value until the first item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)       ins_q <= '0;
		else if (cmd.load) ins_q <= instruction;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q <= rs_value; b_q <= rt_value; pc_q <= pc;
		end
		if (cmd.mul_start) begin
			prod_q <= 64'(ma * mb);
			isdiv_q <= 1'b0;
		end
		if (cmd.div_start) begin
			isdiv_q <= 1'b1;
			dzero_q <= (b_q == 32'd0);
			dvd_q <= (long_sgn && a_q[31]) ? (32'd0 - a_q) : a_q;
			dvs_q <= (long_sgn && b_q[31]) ? (32'd0 - b_q) : b_q;
			neg_q_q <= long_sgn && (a_q[31] != b_q[31]);
			neg_r_q <= long_sgn && a_q[31];
			rem_q <= '0;
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				dvd_q <= {dvd_q[30:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				dvd_q <= {dvd_q[30:0], 1'b0};
			end
			cnt_q <= cnt_q + CNT_W'(1);
		end
		reg_write <= we; dest_reg <= wr; write_data <= wd;
		redirect <= redir; target_pc <= tgt; exception <= exc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hi_q <= '0; lo_q <= '0;
		end else if (cmd.finish) begin
			if (!isdiv_q) begin
				hi_q <= prod_q[63:32]; lo_q <= prod_q[31:0];
			end else if (dzero_q) begin
				hi_q <= a_q; lo_q <= 32'hFFFF_FFFF;
			end else begin
				hi_q <= rv; lo_q <= qv;
			end
		end else if (cmd.load) begin
			// nothing: hi/lo move only on committed instructions
		end else if (mthi) begin
			hi_q <= a_q;
		end else if (mtlo) begin
			lo_q <= a_q;
		end
	end

endmodule

FILE: hdl/mips32_integer_execute_core.sv
// Top level of the MIPS32 integer execute core.
// One instruction item is taken, decoded and executed; its single result item is
// held in an output register until taken, and the next item may be accepted in
// that same cycle. ALU, shift, branch, jump and hi/lo move items pass through
// capture and decode/execute. mult/multu go through the registered 33x33
// multiplier; div/divu go through the restoring divider, which produces one
// quotient bit per cycle. hi and lo reset to zero.
module mips32_integer_execute_core import mie_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] instruction,
	input  logic [31:0] rs_value,
	input  logic [31:0] rt_value,
	input  logic [31:0] pc,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        reg_write,
	output logic [4:0]  dest_reg,
	output logic [31:0] write_data,
	output logic        redirect,
	output logic [31:0] target_pc,
	output logic [2:0]  exception
);

	mie_cmd_t cmd;
	mie_sts_t sts;

	mie_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall),
		.sts(sts), .cmd(cmd)
	);

	mie_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.instruction(instruction), .rs_value(rs_value), .rt_value(rt_value), .pc(pc),
		.reg_write(reg_write), .dest_reg(dest_reg), .write_data(write_data),
		.redirect(redirect), .target_pc(target_pc), .exception(exception)
	);

endmodule

FILE: test/mie_exec_checker.sv
// Checker for the integer execute core: predicts each result item and compares it.
`timescale 1ns / 100ps
module mie_exec_checker import mie_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [31:0] instruction,
	input  logic [31:0] rs_value,
	input  logic [31:0] rt_value,
	input  logic [31:0] pc,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        reg_write,
	input  logic [4:0]  dest_reg,
	input  logic [31:0] write_data,
	input  logic        redirect,
	input  logic [31:0] target_pc,
	input  logic [2:0]  exception,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic        we;
		logic [4:0]  rd;
		logic [31:0] wd;
		logic        redir;
		logic [31:0] tgt;
		logic [2:0]  exc;
	} exec_result_t;

	localparam logic [5:0] OP_SPECIAL = 6'h00, OP_REGIMM = 6'h01, OP_J = 6'h02, OP_JAL = 6'h03;
	localparam logic [5:0] OP_BEQ = 6'h04, OP_BNE = 6'h05, OP_BLEZ = 6'h06, OP_BGTZ = 6'h07;
	localparam logic [5:0] OP_ADDI = 6'h08, OP_ADDIU = 6'h09, OP_SLTI = 6'h0A, OP_SLTIU = 6'h0B;
	localparam logic [5:0] OP_ANDI = 6'h0C, OP_ORI = 6'h0D, OP_XORI = 6'h0E, OP_LUI = 6'h0F;
	localparam logic [5:0] OP_COP0 = 6'h10;
	localparam logic [5:0] FN_SLL = 6'h00, FN_SRL = 6'h02, FN_SRA = 6'h03, FN_SLLV = 6'h04;
	localparam logic [5:0] FN_SRLV = 6'h06, FN_SRAV = 6'h07, FN_JR = 6'h08, FN_JALR = 6'h09;
	localparam logic [5:0] FN_SYSCALL = 6'h0C, FN_BREAK = 6'h0D, FN_MFHI = 6'h10;
	localparam logic [5:0] FN_MTHI = 6'h11, FN_MFLO = 6'h12, FN_MTLO = 6'h13;
	localparam logic [5:0] FN_MULT = 6'h18, FN_MULTU = 6'h19, FN_DIV = 6'h1A, FN_DIVU = 6'h1B;
	localparam logic [5:0] FN_ADD = 6'h20, FN_ADDU = 6'h21, FN_SUB = 6'h22, FN_SUBU = 6'h23;
	localparam logic [5:0] FN_AND = 6'h24, FN_OR = 6'h25, FN_XOR = 6'h26, FN_NOR = 6'h27;
	localparam logic [5:0] FN_SLT = 6'h2A, FN_SLTU = 6'h2B;
	localparam logic [4:0] RT_BLTZ = 5'd0, RT_BGEZ = 5'd1, RT_BLTZAL = 5'd16, RT_BGEZAL = 5'd17;
	localparam logic [4:0] LINK_REG = 5'd31;

	logic [31:0] hi_q, lo_q;
	exec_result_t expected_q[$];

	function automatic void set_write(inout exec_result_t r, input logic [4:0] rd,
			input logic [31:0] v);
		if (rd != 5'd0) begin
			r.we = 1'b1;
			r.rd = rd;
			r.wd = v;
		end
	endfunction

	function automatic void take_branch(inout exec_result_t r, input logic take,
			input logic [31:0] p, input logic [31:0] off);
		if (take) begin
			r.redir = 1'b1;
			r.tgt = p + 32'd4 + (off << 2);
		end
	endfunction

	// hi/lo side effects are applied here, so call once per accepted item
	function automatic exec_result_t execute_item(input logic [31:0] ins,
			input logic [31:0] a, input logic [31:0] b, input logic [31:0] p);
		exec_result_t r;
		logic [5:0] op, fn;
		logic [4:0] rs, rt, rd, sa;
		logic [31:0] simm, uimm, s, ua, ub, q, rm;
		logic [63:0] prod;
		r = '0;
		op = ins[31:26]; fn = ins[5:0];
		rs = ins[25:21]; rt = ins[20:16]; rd = ins[15:11]; sa = ins[10:6];
		uimm = {16'd0, ins[15:0]};
		simm = {{16{ins[15]}}, ins[15:0]};
		case (op)
			OP_SPECIAL: begin
				if (sa == 0 && fn >= FN_ADD && fn <= FN_SLTU && fn != 6'h28 && fn != 6'h29) begin
					case (fn)
						FN_ADD: begin
							s = a + b;
							if (a[31] == b[31] && s[31] != a[31]) r.exc = EXC_OVF;
							else set_write(r, rd, s);
						end
						FN_ADDU: set_write(r, rd, a + b);
						FN_SUB: begin
							s = a - b;
							if (a[31] != b[31] && s[31] != a[31]) r.exc = EXC_OVF;
							else set_write(r, rd, s);
						end
						FN_SUBU: set_write(r, rd, a - b);
						FN_AND: set_write(r, rd, a & b);
						FN_OR: set_write(r, rd, a | b);
						FN_XOR: set_write(r, rd, a ^ b);
						FN_NOR: set_write(r, rd, ~(a | b));
						FN_SLT: set_write(r, rd, {31'd0, $signed(a) < $signed(b)});
						default: set_write(r, rd, {31'd0, a < b});
					endcase
				end else if (rs == 0 && fn == FN_SLL) set_write(r, rd, b << sa);
				else if (rs == 0 && fn == FN_SRL) set_write(r, rd, b >> sa);
				else if (rs == 0 && fn == FN_SRA) set_write(r, rd, $signed(b) >>> sa);
				else if (sa == 0 && fn == FN_SLLV) set_write(r, rd, b << a[4:0]);
				else if (sa == 0 && fn == FN_SRLV) set_write(r, rd, b >> a[4:0]);
				else if (sa == 0 && fn == FN_SRAV) set_write(r, rd, $signed(b) >>> a[4:0]);
				else if (rd == 0 && sa == 0 && fn >= FN_MULT && fn <= FN_DIVU) begin
					if (fn == FN_MULT || fn == FN_MULTU) begin
						if (fn == FN_MULT)
							prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
						else
							prod = {32'd0, a} * {32'd0, b};
						hi_q = prod[63:32];
						lo_q = prod[31:0];
					end else if (b == 0) begin
						lo_q = '1;
						hi_q = a;
					end else if (fn == FN_DIVU) begin
						lo_q = a / b;
						hi_q = a % b;
					end else begin
						ua = a[31] ? -a : a;
						ub = b[31] ? -b : b;
						q = ua / ub;
						rm = ua % ub;
						lo_q = (a[31] != b[31]) ? -q : q;
						hi_q = a[31] ? -rm : rm;
					end
				end
				else if (rs == 0 && rt == 0 && sa == 0 && fn == FN_MFHI) set_write(r, rd, hi_q);
				else if (rs == 0 && rt == 0 && sa == 0 && fn == FN_MFLO) set_write(r, rd, lo_q);
				else if (rt == 0 && rd == 0 && sa == 0 && fn == FN_MTHI) hi_q = a;
				else if (rt == 0 && rd == 0 && sa == 0 && fn == FN_MTLO) lo_q = a;
				else if (fn == FN_BREAK) r.exc = EXC_BRK;
				else if (fn == FN_SYSCALL) r.exc = EXC_SYS;
				else if (rt == 0 && rd == 0 && sa == 0 && fn == FN_JR) begin
					r.redir = 1'b1; r.tgt = a;
				end else if (rt == 0 && sa == 0 && fn == FN_JALR) begin
					r.redir = 1'b1; r.tgt = a;
					set_write(r, rd, p + 32'd8);
				end else r.exc = EXC_RI;
			end
			OP_REGIMM: begin
				case (rt)
					RT_BLTZ: take_branch(r, a[31], p, simm);
					RT_BGEZ: take_branch(r, !a[31], p, simm);
					RT_BLTZAL: begin
						take_branch(r, a[31], p, simm);
						set_write(r, LINK_REG, p + 32'd8);
					end
					RT_BGEZAL: begin
						take_branch(r, !a[31], p, simm);
						set_write(r, LINK_REG, p + 32'd8);
					end
					default: r.exc = EXC_RI;
				endcase
			end
			OP_J, OP_JAL: begin
				s = p + 32'd4;
				r.redir = 1'b1;
				r.tgt = {s[31:28], ins[25:0], 2'b00};
				if (op == OP_JAL) set_write(r, LINK_REG, p + 32'd8);
			end
			OP_BEQ: take_branch(r, a == b, p, simm);
			OP_BNE: take_branch(r, a != b, p, simm);
			OP_BLEZ: if (rt == 0) take_branch(r, $signed(a) < 1, p, simm); else r.exc = EXC_RI;
			OP_BGTZ: if (rt == 0) take_branch(r, $signed(a) > 0, p, simm); else r.exc = EXC_RI;
			OP_ADDI: begin
				s = a + simm;
				if (a[31] == simm[31] && s[31] != a[31]) r.exc = EXC_OVF;
				else set_write(r, rt, s);
			end
			OP_ADDIU: set_write(r, rt, a + simm);
			OP_SLTI: set_write(r, rt, {31'd0, $signed(a) < $signed(simm)});
			OP_SLTIU: set_write(r, rt, {31'd0, a < simm});
			OP_ANDI: set_write(r, rt, a & uimm);
			OP_ORI: set_write(r, rt, a | uimm);
			OP_XORI: set_write(r, rt, a ^ uimm);
			OP_LUI: if (rs == 0) set_write(r, rt, uimm << 16); else r.exc = EXC_RI;
			OP_COP0: begin
				r.exc = EXC_RI;
				if ((rs == 0 || rs == 4) && ins[10:3] == 0) r.exc = EXC_UNH;
				else if (rs == 16 && ins[24:6] == 0 && (fn == 6'h18 || fn == 6'h08 ||
						fn == 6'h01 || fn == 6'h02 || fn == 6'h06))
					r.exc = EXC_UNH;
			end
			6'h20, 6'h21, 6'h22, 6'h23, 6'h24, 6'h25, 6'h26,
			6'h28, 6'h29, 6'h2A, 6'h2B, 6'h2E: r.exc = EXC_UNH;
			default: r.exc = EXC_RI;
		endcase
		return r;
	endfunction

	assign pending = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		exec_result_t e, got;
		if (!arst_n) begin
			hi_q <= '0;
			lo_q <= '0;
			expected_q.delete();
			fail_count <= 0;
		end else begin
			if (in_valid && !in_stall)
				expected_q.push_back(execute_item(instruction, rs_value, rt_value, pc));
			if (out_valid && !out_stall) begin
				got = '{reg_write, dest_reg, write_data, redirect, target_pc, exception};
				if (expected_q.size() == 0) begin
					if (fail_count < 10) $display("unexpected result item %p", got);
					fail_count <= fail_count + 1;
				end else begin
					e = expected_q.pop_front();
					if (got !== e) begin
						if (fail_count < 10) $display("mismatch: expected %p actual %p", e, got);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

FILE: test/tb_mips32_integer_execute_core.sv
// Testbench top: drives instruction items into the execute core and reports the verdict.
`timescale 1ns / 100ps
module tb_mips32_integer_execute_core;
	import mie_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [31:0] instruction = '0, rs_value = '0, rt_value = '0, pc = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        reg_write, redirect;
	logic [4:0]  dest_reg;
	logic [31:0] write_data, target_pc;
	logic [2:0]  exception;
	int          fail_count, pending;
	bit          calm;

	always #2 clk = ~clk;

	mips32_integer_execute_core dut (.*);

	mie_exec_checker checker_i (.*);

	// receiver stalls about 28% of cycles except in the calm stretch
	always @(posedge clk) out_stall <= !calm && ($urandom_range(99) < 28);

	function automatic logic [31:0] pick_operand();
		case ($urandom_range(5))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'h7FFF_FFFF;
			4: return $urandom_range(8);
			default: return $urandom();
		endcase
	endfunction

	// mostly valid encodings with random fields; some fully random words
	function automatic logic [31:0] pick_instruction();
		logic [31:0] w;
		logic [5:0] fns[20] = '{6'h00, 6'h02, 6'h03, 6'h04, 6'h06, 6'h07, 6'h08, 6'h09,
			6'h10, 6'h12, 6'h11, 6'h13, 6'h18, 6'h19, 6'h1A, 6'h1B, 6'h20, 6'h22, 6'h2A, 6'h2B};
		w = $urandom();
		case ($urandom_range(9))
			0, 1, 2: begin
				w[31:26] = 6'h00;
				w[5:0] = ($urandom_range(3) == 0) ? 6'(20 + $urandom_range(0, 11) + 12)
					: fns[$urandom_range(19)];
				if ($urandom_range(3) != 0) begin
					if (w[5:0] inside {6'h00, 6'h02, 6'h03, 6'h10, 6'h12}) w[25:21] = 0;
					else w[10:6] = 0;
					if (w[5:0] inside {6'h10, 6'h12}) w[20:16] = 0;
					if (w[5:0] inside {6'h08, 6'h11, 6'h13}) w[20:11] = 0;
					if (w[5:0] inside {6'h18, 6'h19, 6'h1A, 6'h1B}) w[15:11] = 0;
					if (w[5:0] == 6'h09) w[20:16] = 0;
				end
			end
			3: begin
				w[31:26] = 6'h01;
				w[20:16] = ($urandom_range(4) == 0) ? 5'($urandom())
					: {1'($urandom_range(1)), 3'd0, 1'($urandom_range(1))};
			end
			4, 5, 6: w[31:26] = 6'($urandom_range(2, 15));
			7: w[31:26] = 6'($urandom_range(6, 7));
			8: w[31:26] = ($urandom_range(1)) ? 6'h10 : 6'($urandom_range(32, 46));
			default: ;
		endcase
		if (w[31:26] inside {6'h06, 6'h07, 6'h0F} && $urandom_range(3) != 0) begin
			if (w[31:26] == 6'h0F) w[25:21] = 0; else w[20:16] = 0;
		end
		return w;
	endfunction

	task automatic send_item(input logic [31:0] ins, input logic [31:0] a,
			input logic [31:0] b, input logic [31:0] p);
		while (!calm && $urandom_range(99) < 28) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		instruction <= ins;
		rs_value <= a;
		rt_value <= b;
		pc <= p;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	initial begin
		logic [31:0] directed[25] = '{
			32'h0022_1820, 32'h0022_1822, 32'h0022_1821, 32'h0022_1827, 32'h0022_182A,
			32'h0022_182B, 32'h0002_1FC3, 32'h0041_1806, 32'h0022_0018, 32'h0000_1810,
			32'h0022_001A, 32'h0000_1812, 32'h0022_001B, 32'h0020_0011, 32'h0000_2010,
			32'h2021_8000, 32'h2C21_FFFF, 32'h3C01_FFFF, 32'h0420_0004, 32'h0C3F_FFFF,
			32'h0020_F809, 32'h0000_000C, 32'h0000_000D, 32'h8C00_0000, 32'h4200_0018};
		logic [31:0] a_vals[4] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0};
		logic [31:0] b_vals[4] = '{32'h0000_0001, 32'hFFFF_FFFF, 32'h0, 32'h8000_0000};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < 25; i++)
			send_item(directed[i], a_vals[i % 4], b_vals[(i / 4) % 4], 32'hFFFF_FFF0 + i);
		for (int i = 0; i < 1500; i++) begin
			calm = (i >= 600 && i < 800);
			send_item(pick_instruction(), pick_operand(), pick_operand(), $urandom());
		end
		calm = 1'b0;
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
